/* hw/rtl/ipu_pkg.sv */
// Shared types and constants for the integer pixel upscaler.
// Holds the register codes, result kinds, queue command and status types.
// No dependencies; every other file uses it by scoped name.
package ipu_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF = 16;

  localparam int PIXEL_W     = 24;
  localparam int KIND_W      = 2;
  localparam int SCALE_REG_W = 5;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;

  // Working widths that cover the full parameter ranges (scale to 61, width to 8192).
  localparam int SCALE_EXT_W = 7;
  localparam int WIDTH_EXT_W = 14;
  localparam int CMD_SCALE_W = 6;
  localparam int STEP_W      = 7;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH = 1'd1;

  localparam logic REQ_NEW    = 1'b0;
  localparam logic REQ_REPLAY = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  // One queued unit of back-end work: all results caused by one input item.
  typedef struct packed {
    logic                   reject;
    logic [PIXEL_W-1:0]     px;
    logic                   at_end;
    logic [CMD_SCALE_W-1:0] scale;
    logic [1:0]             pad;
  } cmd_t;

  typedef struct packed {
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

endpackage

/* hw/rtl/ipu_in_if.sv */
// Input item channel of the integer pixel upscaler: valid, ready and payload.
// Depends on ipu_pkg for field widths.
interface ipu_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [ipu_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

/* hw/rtl/ipu_out_if.sv */
// Result channel of the integer pixel upscaler: valid, ready and payload.
// Depends on ipu_pkg for field widths.
interface ipu_out_if;
  logic                        valid;
  logic                        ready;
  logic [ipu_pkg::KIND_W-1:0]  kind;
  logic [ipu_pkg::PIXEL_W-1:0] data;
  logic                        row_end;
  logic                        last;

  modport source (output valid, output kind, output data, output row_end, output last,
                  input ready);
  modport sink   (input valid, input kind, input data, input row_end, input last,
                  output ready);
endinterface

/* hw/rtl/ipu_front.sv */
// Front end of the upscaler: configuration registers, phase tracking, line buffer.
// Classifies each input transfer and pushes one command into the queue.
// Depends on ipu_pkg.
module ipu_front #(
  parameter int MAX_WIDTH = ipu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = ipu_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [ipu_pkg::PIXEL_W-1:0]    in_pixel,
  input  ipu_pkg::q_status_t             q_stat,
  output logic                           push,
  output ipu_pkg::cmd_t                  push_cmd
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RC_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SXW   = ipu_pkg::SCALE_EXT_W;
  localparam int WXW   = ipu_pkg::WIDTH_EXT_W;

  logic [ipu_pkg::SCALE_REG_W-1:0] scale_r;
  logic [ipu_pkg::WIDTH_REG_W-1:0] in_width_r;
  logic [COL_W-1:0]                column_r;
  logic [RC_W-1:0]                 row_copy_r;
  logic                            replaying_r;

  logic [ipu_pkg::PIXEL_W-1:0]     row_mem [MAX_WIDTH];
  logic [ipu_pkg::PIXEL_W-1:0]     rd_data_r;

  logic                            s1_valid_r;
  logic                            s1_reject_r;
  logic                            s1_replay_r;
  logic [ipu_pkg::PIXEL_W-1:0]     s1_px_r;
  logic                            s1_at_end_r;
  logic [ipu_pkg::CMD_SCALE_W-1:0] s1_scale_r;
  logic [1:0]                      s1_pad_r;

  logic [SXW-1:0] eff_scale;
  logic [WXW-1:0] eff_width;
  logic [WXW:0]   col_inc;
  logic           at_end;
  logic           accept;
  logic           reject;
  logic [3:0]     pad_prod;
  logic [RC_W-1:0] rc_inc;
  logic           replay_done;

  // Out-of-range registers are clamped to the legal range.
  always_comb begin
    if (scale_r == '0) begin
      eff_scale = SXW'(1);
    end else if ({2'b00, scale_r} > SXW'(MAX_SCALE)) begin
      eff_scale = SXW'(MAX_SCALE);
    end else begin
      eff_scale = {2'b00, scale_r};
    end
    if (in_width_r == '0) begin
      eff_width = WXW'(1);
    end else if ({3'b000, in_width_r} > WXW'(MAX_WIDTH)) begin
      eff_width = WXW'(MAX_WIDTH);
    end else begin
      eff_width = {3'b000, in_width_r};
    end
  end

  assign col_inc  = (WXW + 1)'(column_r) + 1'b1;
  assign at_end   = col_inc >= {1'b0, eff_width};
  assign pad_prod = {2'b00, eff_width[1:0]} * {2'b00, eff_scale[1:0]};
  assign rc_inc   = row_copy_r + 1'b1;
  assign replay_done = (SXW'(rc_inc) + 1'b1 >= eff_scale) || (rc_inc == '0);

  // The stage register always drains into the queue, so room is counted ahead.
  assign in_ready = (4'(q_stat.count) + 4'(s1_valid_r)) < 4'(ipu_pkg::Q_DEPTH);
  assign accept   = in_valid && in_ready;
  assign reject   = (in_req_type == ipu_pkg::REQ_REPLAY) != replaying_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= ipu_pkg::SCALE_REG_W'(1);
      in_width_r <= ipu_pkg::WIDTH_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipu_pkg::REG_SCALE:    scale_r    <= cfg_wdata[ipu_pkg::SCALE_REG_W-1:0];
        ipu_pkg::REG_IN_WIDTH: in_width_r <= cfg_wdata[ipu_pkg::WIDTH_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r    <= '0;
      row_copy_r  <= '0;
      replaying_r <= 1'b0;
    end else if (accept && !reject) begin
      if (!at_end) begin
        column_r <= column_r + 1'b1;
      end else begin
        column_r <= '0;
        if (!replaying_r) begin
          row_copy_r  <= '0;
          replaying_r <= eff_scale > SXW'(1);
        end else if (replay_done) begin
          row_copy_r  <= '0;
          replaying_r <= 1'b0;
        end else begin
          row_copy_r <= rc_inc;
        end
      end
    end
  end

  // Line buffer: new pixels write, replay items read in the cycle before the push.
  always_ff @(posedge clk) begin
    if (accept && !reject && !replaying_r) begin
      row_mem[column_r] <= in_pixel;
    end
    if (accept && !reject && replaying_r) begin
      rd_data_r <= row_mem[column_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_reject_r <= reject;
      s1_replay_r <= replaying_r;
      s1_px_r     <= in_pixel;
      s1_at_end_r <= at_end;
      s1_scale_r  <= ipu_pkg::CMD_SCALE_W'(eff_scale);
      s1_pad_r    <= at_end ? pad_prod[1:0] : 2'b00;
    end
  end

  assign push            = s1_valid_r;
  assign push_cmd.reject = s1_reject_r;
  assign push_cmd.px     = s1_replay_r ? rd_data_r : s1_px_r;
  assign push_cmd.at_end = s1_at_end_r;
  assign push_cmd.scale  = s1_scale_r;
  assign push_cmd.pad    = s1_pad_r;

endmodule

/* hw/rtl/ipu_cmd_queue.sv */
// Short command queue between the upscaler front end and back end.
// Register-based ring of ipu_pkg::Q_DEPTH entries; depends on ipu_pkg.
module ipu_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ipu_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output ipu_pkg::cmd_t      head,
  output ipu_pkg::q_status_t stat
);

  ipu_pkg::cmd_t                slot_r [ipu_pkg::Q_DEPTH];
  logic [ipu_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [ipu_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [ipu_pkg::Q_CNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

/* hw/rtl/ipu_back.sv */
// Back end of the upscaler: expands the queue head into pixel copies and pad bytes,
// or one reject result; drives the registered result channel, depends on ipu_pkg.
module ipu_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ipu_pkg::cmd_t               head,
  input  ipu_pkg::q_status_t          q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ipu_pkg::KIND_W-1:0]  out_kind,
  output logic [ipu_pkg::PIXEL_W-1:0] out_data,
  output logic                        out_row_end,
  output logic                        out_last
);

  localparam int SW = ipu_pkg::STEP_W;

  logic [SW-1:0]               step_r;
  logic                        out_valid_r;
  logic [ipu_pkg::KIND_W-1:0]  out_kind_r;
  logic [ipu_pkg::PIXEL_W-1:0] out_data_r;
  logic                        out_row_end_r;
  logic                        out_last_r;

  logic          advance;
  logic          emit;
  logic [SW-1:0] total;
  logic          is_last;
  logic          is_pixel;

  assign advance  = !out_valid_r || out_ready;
  assign emit     = advance && !q_stat.empty;
  assign total    = head.reject ? SW'(1) : SW'(head.scale) + SW'(head.pad);
  assign is_last  = (step_r == total - 1'b1);
  assign is_pixel = step_r < SW'(head.scale);
  assign pop      = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= !q_stat.empty;
      if (emit) begin
        step_r <= is_last ? '0 : step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_last_r    <= is_last;
      out_row_end_r <= !head.reject && head.at_end && is_last;
      if (head.reject) begin
        out_kind_r <= ipu_pkg::KIND_REJECT;
        out_data_r <= '0;
      end else if (is_pixel) begin
        out_kind_r <= ipu_pkg::KIND_PIXEL;
        out_data_r <= head.px;
      end else begin
        out_kind_r <= ipu_pkg::KIND_PAD;
        out_data_r <= '0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_data    = out_data_r;
  assign out_row_end = out_row_end_r;
  assign out_last    = out_last_r;

endmodule

/* hw/rtl/integer_pixel_upscaler_core.sv */
// Top level of the nearest-neighbor integer pixel upscaler.
// Instantiates ipu_front, ipu_cmd_queue and ipu_back; depends on ipu_pkg and the
// ipu_in_if / ipu_out_if channel interfaces.
//
//   Channel   Direction  Handshake        Payload
//   in_ch     sink       valid / ready    req_type, pixel
//   out_ch    source     valid / ready    kind, data, row_end, last
//   cfg_*     sink       cfg_we only      cfg_index, cfg_wdata
//
// Each input transfer yields 1 result (rejected item) or scale + pad results
// (pad is 0..3, only at the end of a row), one result per cycle while out_ch is
// not stalled; the back end's step counter walks through them. Input is taken
// every cycle while the four-entry queue has room. The first result of an item
// passes the front end's stage register, a queue slot and the back end's output
// register before it is valid.
// Reset is synchronous and active low; the line buffer is not cleared.
// A stalled output holds its register and the queue absorbs the front end.
module integer_pixel_upscaler_core #(
  parameter int MAX_WIDTH = ipu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = ipu_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ipu_in_if.sink                         in_ch,
  ipu_out_if.source                      out_ch
);

  // Command path from the front end into the queue, and from the queue head to the
  // back end. The queue status tells the front end how much room is left.
  logic               push;
  ipu_pkg::cmd_t      push_cmd;
  logic               pop;
  ipu_pkg::cmd_t      head;
  ipu_pkg::q_status_t q_stat;

  // The front end tracks the row position and the replay phase, stores new pixels
  // in the line buffer and reads them back for replay items.
  ipu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .in_pixel    (in_ch.pixel),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  ipu_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // The back end pops a command as its last result is registered.
  ipu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_data    (out_ch.data),
    .out_row_end (out_ch.row_end),
    .out_last    (out_ch.last)
  );

endmodule

/* hw/rtl/ipu_checker.sv */
// Port-level checks on the result channel of integer_pixel_upscaler_core.
// Bound to the top level below; depends on ipu_pkg for the result kinds.
module ipu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ipu_pkg::KIND_W-1:0]  out_kind,
  input logic [ipu_pkg::PIXEL_W-1:0] out_data,
  input logic                        out_row_end,
  input logic                        out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_kind))
    else $error("stalled result changed");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ipu_pkg::KIND_REJECT |-> out_last && !out_row_end
      && out_data == '0)
    else $error("rejected item result malformed");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ipu_pkg::KIND_PAD |-> out_data == '0)
    else $error("pad byte carries data");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == ipu_pkg::KIND_PIXEL || out_kind == ipu_pkg::KIND_PAD
      || out_kind == ipu_pkg::KIND_REJECT)
    else $error("undefined result kind");

endmodule

bind integer_pixel_upscaler_core ipu_checker u_ipu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_data    (out_ch.data),
  .out_row_end (out_ch.row_end),
  .out_last    (out_ch.last)
);
